[hdl/pli_pkg.sv]
// ----------------------------------------------------------------------------
// pli_pkg
// Shared constants, types and command codes of the piecewise linear
// interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam int MAX_POINTS = 32;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int ENTRY_W    = 5;
    localparam int CNT_W      = 6;
    localparam int X_W        = 16;
    localparam int Y_W        = 20;
    localparam int REGION_W   = 2;
    localparam int SEG_W      = 5;
    localparam int WORD_W     = X_W + Y_W;
    localparam int PROD_W     = X_W + 1 + Y_W + 1;
    localparam int DIV_W      = X_W + Y_W;
    localparam int DIVC_W     = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(2);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [REGION_W-1:0] REGION_BELOW  = 2'd0;
    localparam logic [REGION_W-1:0] REGION_ABOVE  = 2'd1;
    localparam logic [REGION_W-1:0] REGION_INSIDE = 2'd2;
    localparam logic [REGION_W-1:0] REGION_NONE   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOW,
        S_HIGH,
        S_SCAN,
        S_MUL,
        S_DIV_INIT,
        S_DIV,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        FN_NOP,
        FN_LOW,
        FN_HIGH,
        FN_MISS,
        FN_FLAT,
        FN_INTERP
    } t_fin;

    typedef struct packed {
        logic             wr_en;
        logic             ld_query;
        logic             ld_left;
        logic             ld_right;
        logic             mul;
        logic             div_init;
        logic             div_step;
        t_fin             fin;
        logic [IDX_W-1:0] rd_addr;
        logic [IDX_W-1:0] seg;
    } t_dp_cmd;

    typedef struct packed {
        logic             below;
        logic             above;
        logic             in_seg;
        logic             flat;
        logic [IDX_W-1:0] last;
    } t_dp_stat;

endpackage

[hdl/pli_ram.sv]
// ----------------------------------------------------------------------------
// pli_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/pli_ctrl.sv]
// ----------------------------------------------------------------------------
// pli_ctrl
// Controller: issues the table write for each write item and, for each query
// item, sequences the table search, the multiply and the bit-serial divide.
// ----------------------------------------------------------------------------
module pli_ctrl
    import pli_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_operation,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [DIVC_W-1:0]   r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_idx <= n_idx;
        r_cnt <= n_cnt;
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.fin = FN_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_operation == OP_WRITE) begin
                        o_cmd.wr_en = 1'b1;
                    end else begin
                        o_cmd.ld_query = 1'b1;
                        n_state = S_LOW;
                    end
                end
            end
            S_LOW: begin
                o_cmd.ld_left = 1'b1;
                if (i_stat.below) begin
                    o_cmd.fin = FN_LOW;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_addr = i_stat.last;
                    n_state = S_HIGH;
                end
            end
            S_HIGH: begin
                if (i_stat.above) begin
                    o_cmd.fin = FN_HIGH;
                    n_state = S_IDLE;
                end else if (i_stat.last == '0) begin
                    o_cmd.fin = FN_MISS;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_addr = IDX_W'(1);
                    n_idx = IDX_W'(1);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.seg = r_idx - IDX_W'(1);
                if (i_stat.in_seg) begin
                    o_cmd.ld_right = 1'b1;
                    n_state = S_MUL;
                end else begin
                    o_cmd.ld_left = 1'b1;
                    if (r_idx == i_stat.last) begin
                        o_cmd.fin = FN_MISS;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_addr = r_idx + IDX_W'(1);
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                if (i_stat.flat) begin
                    o_cmd.fin = FN_FLAT;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_cnt = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + DIVC_W'(1);
                if (r_cnt == DIVC_W'(DIV_W - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = FN_INTERP;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[hdl/pli_dp.sv]
// ----------------------------------------------------------------------------
// pli_dp
// Datapath: breakpoint table, point count register, segment compares,
// multiplier, restoring divider and result registers.
// ----------------------------------------------------------------------------
module pli_dp
    import pli_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    input  logic                       i_cfg_we,
    input  logic [CNT_W-1:0]           i_cfg_wdata,
    input  logic [ENTRY_W-1:0]         i_entry_index,
    input  logic [X_W-1:0]             i_entry_x,
    input  logic signed [Y_W-1:0]      i_entry_y,
    input  logic [X_W-1:0]             i_query_x,
    output t_dp_stat                   o_stat,
    output logic                       o_strobe,
    output logic signed [Y_W-1:0]      o_value,
    output logic [REGION_W-1:0]        o_region,
    output logic [SEG_W-1:0]           o_segment
);

    logic [CNT_W-1:0]          r_count;
    logic [X_W-1:0]            r_q;
    logic [X_W-1:0]            r_xl, r_xr;
    logic signed [Y_W-1:0]     r_yl, r_yr;
    logic [IDX_W-1:0]          r_seg;
    logic signed [PROD_W-1:0]  r_prod;
    logic [X_W-1:0]            r_dx;
    logic                      r_neg;
    logic [X_W-1:0]            r_rem;
    logic [DIV_W-1:0]          r_quo;
    logic                      r_strobe;
    logic signed [Y_W-1:0]     r_value;
    logic [REGION_W-1:0]       r_region;
    logic [IDX_W-1:0]          r_segment;

    logic                      w_we;
    logic [WORD_W-1:0]         w_rdata;
    logic [X_W-1:0]            w_rd_x;
    logic signed [Y_W-1:0]     w_rd_y;
    logic [X_W-1:0]            w_dq;
    logic signed [Y_W:0]       w_dy;
    logic signed [PROD_W-1:0]  w_prod;
    logic [PROD_W-1:0]         w_mag;
    logic [X_W:0]              w_trial;
    logic                      w_ge;
    logic signed [Y_W+1:0]     w_qmag;
    logic signed [Y_W+1:0]     w_qs;
    logic signed [Y_W+1:0]     w_sum;

    assign w_we = i_cmd.wr_en && (32'(i_entry_index) < MAX_POINTS);

    pli_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (IDX_W'(i_entry_index)),
        .i_wdata ({i_entry_x, i_entry_y}),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (w_rdata)
    );

    assign w_rd_x = w_rdata[WORD_W-1:Y_W];
    assign w_rd_y = $signed(w_rdata[Y_W-1:0]);

    always_comb begin
        o_stat.below  = (r_q < w_rd_x);
        o_stat.above  = (r_q > w_rd_x);
        o_stat.in_seg = (r_q >= r_xl) && (r_q <= w_rd_x);
        o_stat.flat   = (r_dx == '0);
        if (r_count == '0) begin
            o_stat.last = '0;
        end else if (32'(r_count) > MAX_POINTS) begin
            o_stat.last = IDX_W'(MAX_POINTS - 1);
        end else begin
            o_stat.last = IDX_W'(r_count - CNT_W'(1));
        end
    end

    assign w_dq   = r_q - r_xl;
    assign w_dy   = {r_yr[Y_W-1], r_yr} - {r_yl[Y_W-1], r_yl};
    assign w_prod = $signed({1'b0, w_dq}) * w_dy;
    assign w_mag  = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);

    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dx});

    assign w_qmag = $signed({1'b0, r_quo[Y_W:0]});
    assign w_qs   = r_neg ? -w_qmag : w_qmag;
    assign w_sum  = {{2{r_yl[Y_W-1]}}, r_yl} + w_qs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= COUNT_RESET;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            r_strobe <= (i_cmd.fin != FN_NOP);
        end

        if (i_cmd.ld_query) begin
            r_q <= i_query_x;
        end
        if (i_cmd.ld_left) begin
            r_xl <= w_rd_x;
            r_yl <= w_rd_y;
        end
        if (i_cmd.ld_right) begin
            r_xr  <= w_rd_x;
            r_yr  <= w_rd_y;
            r_seg <= i_cmd.seg;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
            r_dx   <= r_xr - r_xl;
        end
        if (i_cmd.div_init) begin
            r_neg <= r_prod[PROD_W-1];
            r_quo <= w_mag[DIV_W-1:0];
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? X_W'(w_trial - {1'b0, r_dx}) : w_trial[X_W-1:0];
        end

        case (i_cmd.fin)
            FN_LOW: begin
                r_value   <= w_rd_y;
                r_region  <= REGION_BELOW;
                r_segment <= '0;
            end
            FN_HIGH: begin
                r_value   <= w_rd_y;
                r_region  <= REGION_ABOVE;
                r_segment <= '0;
            end
            FN_MISS: begin
                r_value   <= '0;
                r_region  <= REGION_NONE;
                r_segment <= '0;
            end
            FN_FLAT: begin
                r_value   <= r_yl;
                r_region  <= REGION_INSIDE;
                r_segment <= r_seg;
            end
            FN_INTERP: begin
                r_value   <= w_sum[Y_W-1:0];
                r_region  <= REGION_INSIDE;
                r_segment <= r_seg;
            end
            default: begin
            end
        endcase
    end

    assign o_strobe  = r_strobe;
    assign o_value   = r_value;
    assign o_region  = r_region;
    assign o_segment = SEG_W'(r_segment);

endmodule

[hdl/piecewise_linear_interp.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_interp
// A write item loads one breakpoint and gives no result. A query item reads
// the first and last breakpoints for the end clamps, then one further
// breakpoint per step of the segment search, then multiplies and runs a
// bit-serial restoring divide of the 36-bit dividend, which a segment of zero
// width skips, and gives its result on the strobe. Clamped and unmatched
// queries finish without the multiply and the divide. The result is held for
// one cycle only, as the receiver cannot stall; busy is low during the strobe.
// ----------------------------------------------------------------------------
module piecewise_linear_interp
    import pli_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_cfg_we,
    input  logic [CNT_W-1:0]       i_cfg_wdata,
    input  logic                   i_operation,
    input  logic [ENTRY_W-1:0]     i_entry_index,
    input  logic [X_W-1:0]         i_entry_x,
    input  logic signed [Y_W-1:0]  i_entry_y,
    input  logic [X_W-1:0]         i_query_x,
    output logic                   o_strobe,
    output logic signed [Y_W-1:0]  o_value,
    output logic [REGION_W-1:0]    o_region,
    output logic [SEG_W-1:0]       o_segment
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    pli_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_busy      (busy)
    );

    pli_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_entry_index (i_entry_index),
        .i_entry_x     (i_entry_x),
        .i_entry_y     (i_entry_y),
        .i_query_x     (i_query_x),
        .o_stat        (w_stat),
        .o_strobe      (o_strobe),
        .o_value       (o_value),
        .o_region      (o_region),
        .o_segment     (o_segment)
    );

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while a query is still in progress");

    a_busy_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted item");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_region == REGION_NONE) |-> (o_value == '0 && o_segment == '0))
        else $error("unmatched query gave a nonzero result");

    a_clamp_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_region == REGION_BELOW || o_region == REGION_ABOVE))
            |-> (o_segment == '0))
        else $error("clamped query reported a segment");

endmodule
